>>> rtl/braille_cell_framebuffer_core_assert.svh
// ----------------------------------------------------------------------------
// Braille cell framebuffer assertion macros
// Concurrent check macros sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BRAILLE_CELL_FRAMEBUFFER_CORE_ASSERT_SVH
`define BRAILLE_CELL_FRAMEBUFFER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define BCF_ASSERT_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("bcf: forbidden condition seen");
`define BCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcf: expected condition missing in next cycle");
`else
`define BCF_ASSERT_NEVER(label, cond)
`define BCF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

>>> rtl/bcf_pkg.sv
// ----------------------------------------------------------------------------
// bcf_pkg
// Shared types, codes and constants of the braille cell framebuffer.
// ----------------------------------------------------------------------------
package bcf_pkg;

    localparam int MAX_WIDTH_PX_DEF  = 256;
    localparam int MAX_HEIGHT_PX_DEF = 256;

    localparam int SZ_W    = 11;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 9;
    localparam int COORD_W = 10;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 8;

    typedef enum logic [1:0] {
        FUNC_SET    = 2'd0,
        FUNC_UNSET  = 2'd1,
        FUNC_CLEAR  = 2'd2,
        FUNC_RENDER = 2'd3
    } func_t;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_PX  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_PX = 4'd1;

    localparam logic [CFG_DATA_W-1:0] WIDTH_PX_RST  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_PX_RST = 9'd256;

    localparam logic [15:0] BRAILLE_BASE = 16'h2800;
    localparam logic [7:0]  UTF8_LEAD3   = 8'hE0;
    localparam logic [7:0]  UTF8_CONT    = 8'h80;
    localparam logic [7:0]  ASCII_SPACE  = 8'h20;
    localparam logic [7:0]  ASCII_NL     = 8'h0A;

    typedef logic [2:0] dot_idx_t;
    localparam dot_idx_t LEFT_DOTS  [4] = '{3'd0, 3'd1, 3'd2, 3'd6};
    localparam dot_idx_t RIGHT_DOTS [4] = '{3'd3, 3'd4, 3'd5, 3'd7};

    typedef struct packed {
        logic load;
        logic decode;
        logic rd;
        logic wr;
        logic build;
        logic clr_step;
        logic out_adv;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  hit;
        logic  last_beat;
        logic  clr_done;
    } sts_t;

    function automatic logic [7:0] dot_mask(input logic col, input logic [1:0] row);
        dot_idx_t d;
        d = col ? RIGHT_DOTS[row] : LEFT_DOTS[row];
        return 8'(1) << d;
    endfunction

endpackage

>>> rtl/braille_cell_framebuffer_core.sv
// ----------------------------------------------------------------------------
// braille_cell_framebuffer_core
// Braille dot-mask store with pixel set/unset, clear and UTF-8 cell render.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | moves
//  ---------+-------------------------------------------+---------------------------
//  s_*      | tvalid tready tdata[23:0] tuser[1:0]      | one item per beat
//  m_*      | tvalid tready tdata[7:0] tlast            | one UTF-8 byte per beat
//  cfg_*    | valid ready index[3:0] data[8:0]          | one size register write
//
//  Set/unset steps per item: accept, decode, mask read, mask write back.
//  Render: accept, decode, mask read, byte build, then 1 to 4 output beats; off-grid: accept, decode.
//  Clear and reset run a pass over the mask memory, one entry per cycle, covering
//  all CPR * ROWS entries (8192 at default size); s_tready low meanwhile.
//  A stalled m_tready holds the current beat; no item is taken until the last beat.
// ----------------------------------------------------------------------------
`include "braille_cell_framebuffer_core_assert.svh"

module braille_cell_framebuffer_core
#(
    parameter int MAX_WIDTH_PX  = bcf_pkg::MAX_WIDTH_PX_DEF,
    parameter int MAX_HEIGHT_PX = bcf_pkg::MAX_HEIGHT_PX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bcf_pkg::S_TDATA_W-1:0]   s_tdata,   // x[9:0], y[19:10], zero pad
    input  logic [1:0]                      s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bcf_pkg::M_TDATA_W-1:0]   m_tdata,   // text_byte[7:0]
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bcf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    bcf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    bcf_dp
    #(
        .MAX_WIDTH_PX  (MAX_WIDTH_PX),
        .MAX_HEIGHT_PX (MAX_HEIGHT_PX)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

    `BCF_ASSERT_NEVER(a_one_item_at_a_time, s_tready && m_tvalid)
    `BCF_ASSERT_NEXT(a_accept_blocks_input, s_tvalid && s_tready, !s_tready)
    `BCF_ASSERT_NEXT(a_last_beat_ends_render, m_tvalid && m_tready && m_tlast, !m_tvalid)
    `BCF_ASSERT_NEVER(a_clear_excludes_write, cmd.clr_step && (cmd.wr || cmd.rd))

endmodule

>>> rtl/bcf_ctrl.sv
// ----------------------------------------------------------------------------
// bcf_ctrl
// Sequencer: clearing pass, item decode, read-modify-write and byte emission.
// ----------------------------------------------------------------------------
module bcf_ctrl
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    output logic         m_tvalid,
    input  logic         m_tready,
    output bcf_pkg::cmd_t cmd,
    input  bcf_pkg::sts_t sts
);
    import bcf_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_READ,
        ST_UPDATE,
        ST_BUILD,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.decode = 1'b1;
                priority if (sts.func == FUNC_CLEAR)
                begin
                    state_next = ST_CLEAR;
                end
                else if (sts.hit)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = (sts.func == FUNC_RENDER) ? ST_BUILD : ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.wr     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BUILD:
            begin
                cmd.build  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                cmd.out_adv = m_tready;
                if (m_tready && sts.last_beat)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_EMIT);

endmodule

>>> rtl/bcf_dp.sv
// ----------------------------------------------------------------------------
// bcf_dp
// Size registers, pixel and cell decode, mask store and UTF-8 byte buffer.
// ----------------------------------------------------------------------------
module bcf_dp
#(
    parameter int MAX_WIDTH_PX  = bcf_pkg::MAX_WIDTH_PX_DEF,
    parameter int MAX_HEIGHT_PX = bcf_pkg::MAX_HEIGHT_PX_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [bcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bcf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bcf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [1:0]                      s_tuser,
    output logic [bcf_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast,
    input  bcf_pkg::cmd_t                   cmd,
    output bcf_pkg::sts_t                   sts
);
    import bcf_pkg::*;

    localparam int CPR    = (MAX_WIDTH_PX + 1) / 2;
    localparam int ROWS   = (MAX_HEIGHT_PX + 3) / 4;
    localparam int DEPTH  = CPR * ROWS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;

    func_t              func_reg;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  addr_next;
    logic [7:0]         bit_reg;
    logic               eol_reg;
    logic               eol_next;
    logic [7:0]         rdata_reg;
    logic [ADDR_W-1:0]  clr_cnt_reg;
    logic               clr_last;

    logic [7:0]         mem [DEPTH];

    logic [7:0]         byte_reg [4];
    logic [1:0]         last_idx_reg;
    logic [1:0]         beat_idx_reg;

    logic [SZ_W-1:0]    eff_w;
    logic [SZ_W-1:0]    eff_h;
    logic [SZ_W-1:0]    cw;
    logic [SZ_W-1:0]    ch;
    logic [SZ_W-1:0]    xe;
    logic [SZ_W-1:0]    ye;
    logic [SZ_W-1:0]    cx;
    logic [SZ_W-1:0]    cy;
    logic               is_render;
    logic               hit;
    logic [15:0]        cp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_PX_RST;
            height_reg <= HEIGHT_PX_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WIDTH_PX)
            begin
                width_reg <= cfg_data;
            end
            if (cfg_index == CFG_HEIGHT_PX)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        eff_w = ({2'b00, width_reg} > SZ_W'(MAX_WIDTH_PX)) ?
                SZ_W'(MAX_WIDTH_PX) : {2'b00, width_reg};
        eff_h = ({2'b00, height_reg} > SZ_W'(MAX_HEIGHT_PX)) ?
                SZ_W'(MAX_HEIGHT_PX) : {2'b00, height_reg};
        cw    = (eff_w + SZ_W'(1)) >> 1;
        ch    = (eff_h + SZ_W'(3)) >> 2;
        xe    = {1'b0, x_reg};
        ye    = {1'b0, y_reg};
        is_render = (func_reg == FUNC_RENDER);
        if (is_render)
        begin
            hit = !x_reg[COORD_W-1] && !y_reg[COORD_W-1] && (xe < cw) && (ye < ch);
            cx  = xe;
            cy  = ye;
        end
        else
        begin
            hit = !x_reg[COORD_W-1] && !y_reg[COORD_W-1] && (xe < eff_w) && (ye < eff_h);
            cx  = xe >> 1;
            cy  = ye >> 2;
        end
        addr_next = ADDR_W'(cy) * ADDR_W'(CPR) + ADDR_W'(cx);
        eol_next  = (xe == cw - SZ_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func_t'(s_tuser);
            x_reg    <= s_tdata[COORD_W-1:0];
            y_reg    <= s_tdata[2*COORD_W-1:COORD_W];
        end
        if (cmd.decode)
        begin
            addr_reg <= addr_next;
            bit_reg  <= dot_mask(x_reg[0], y_reg[1:0]);
            eol_reg  <= eol_next;
        end
    end

    assign clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_last ? '0 : clr_cnt_reg + ADDR_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clr_step)
        begin
            mem[clr_cnt_reg] <= 8'h00;
        end
        else if (cmd.wr)
        begin
            mem[addr_reg] <= (func_reg == FUNC_UNSET) ? (rdata_reg & ~bit_reg)
                                                      : (rdata_reg | bit_reg);
        end
        if (cmd.rd)
        begin
            rdata_reg <= mem[addr_reg];
        end
    end

    assign cp = BRAILLE_BASE + {8'h00, rdata_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.build)
        begin
            if (rdata_reg == 8'h00)
            begin
                byte_reg[0]  <= ASCII_SPACE;
                byte_reg[1]  <= ASCII_NL;
                byte_reg[2]  <= ASCII_NL;
                last_idx_reg <= eol_reg ? 2'd1 : 2'd0;
            end
            else
            begin
                byte_reg[0]  <= UTF8_LEAD3 | {4'h0, cp[15:12]};
                byte_reg[1]  <= UTF8_CONT | {2'b00, cp[11:6]};
                byte_reg[2]  <= UTF8_CONT | {2'b00, cp[5:0]};
                last_idx_reg <= eol_reg ? 2'd3 : 2'd2;
            end
            byte_reg[3] <= ASCII_NL;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_idx_reg <= '0;
        end
        else if (cmd.build)
        begin
            beat_idx_reg <= '0;
        end
        else if (cmd.out_adv)
        begin
            beat_idx_reg <= beat_idx_reg + 2'd1;
        end
    end

    assign m_tdata = byte_reg[beat_idx_reg];
    assign m_tlast = (beat_idx_reg == last_idx_reg);

    assign sts.func      = func_reg;
    assign sts.hit       = hit;
    assign sts.last_beat = m_tlast;
    assign sts.clr_done  = clr_last;

endmodule

>>> test/braille_cell_framebuffer_core_test.sv
// ----------------------------------------------------------------------------
// braille_cell_framebuffer_core_test
// Drives pixel set/unset, clear and render items into the framebuffer core,
// writes the size registers between phases and checks every UTF-8 output
// beat against a cycle-free model of the dot-mask store.
// ----------------------------------------------------------------------------
module braille_cell_framebuffer_core_test;

    import bcf_pkg::*;

    localparam int CELLS_PER_ROW = (MAX_WIDTH_PX_DEF + 1) / 2;
    localparam int CELL_ROWS     = (MAX_HEIGHT_PX_DEF + 3) / 4;
    localparam int CELL_COUNT    = CELLS_PER_ROW * CELL_ROWS;
    localparam int ITEM_SETTLE   = 16;
    localparam int CLEAR_SETTLE  = CELL_COUNT + 64;
    localparam int LIMIT_CYCLES  = 1000000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 4'd15;

    localparam logic [7:0]  SPACE_CHAR   = 8'h20;
    localparam logic [7:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [15:0] BRAILLE_ROW  = 16'h2800;

    typedef struct {
        logic [7:0] text_byte;
        logic       last;
    } text_beat_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic [1:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [7:0]             cell_masks [CELL_COUNT];
    logic [8:0]             width_cfg;
    logic [8:0]             height_cfg;
    text_beat_t             text_q [$];
    int                     errors;
    int                     cycles;
    int                     hold_left;
    bit                     idle_on;
    bit                     clear_pending;
    int                     clears_left;

    braille_cell_framebuffer_core i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic int eff_size(logic [8:0] v, int limit);
        return (int'(v) > limit) ? limit : int'(v);
    endfunction

    function automatic logic [2:0] dot_bit(logic col, logic [1:0] row);
        case ({col, row})
            3'b000:  return 3'd0;
            3'b001:  return 3'd1;
            3'b010:  return 3'd2;
            3'b011:  return 3'd6;
            3'b100:  return 3'd3;
            3'b101:  return 3'd4;
            3'b110:  return 3'd5;
            default: return 3'd7;
        endcase
    endfunction

    task automatic push_byte(logic [7:0] b);
        text_beat_t t;
        t.text_byte = b;
        t.last = 1'b0;
        text_q.push_back(t);
    endtask

    task automatic predict_text(func_t f, logic [9:0] xv, logic [9:0] yv);
        int xi;
        int yi;
        int w;
        int h;
        int cw;
        int ch;
        int idx;
        logic [7:0] m;
        logic [15:0] cp;
        text_beat_t t;
        xi = $signed(xv);
        yi = $signed(yv);
        w  = eff_size(width_cfg, MAX_WIDTH_PX_DEF);
        h  = eff_size(height_cfg, MAX_HEIGHT_PX_DEF);
        cw = (w + 1) / 2;
        ch = (h + 3) / 4;
        case (f)
            FUNC_SET, FUNC_UNSET:
            begin
                if (xi >= 0 && yi >= 0 && xi < w && yi < h)
                begin
                    idx = (yi / 4) * CELLS_PER_ROW + xi / 2;
                    if (f == FUNC_SET)
                        cell_masks[idx][dot_bit(xv[0], yv[1:0])] = 1'b1;
                    else
                        cell_masks[idx][dot_bit(xv[0], yv[1:0])] = 1'b0;
                end
            end
            FUNC_CLEAR:
            begin
                foreach (cell_masks[i])
                    cell_masks[i] = 8'h00;
                clear_pending = 1'b1;
            end
            default:
            begin
                if (xi >= 0 && yi >= 0 && xi < cw && yi < ch)
                begin
                    m = cell_masks[yi * CELLS_PER_ROW + xi];
                    if (m == 8'h00)
                        push_byte(SPACE_CHAR);
                    else
                    begin
                        cp = BRAILLE_ROW + {8'h00, m};
                        push_byte(8'hE0 | {4'h0, cp[15:12]});
                        push_byte(8'h80 | {2'b00, cp[11:6]});
                        push_byte(8'h80 | {2'b00, cp[5:0]});
                    end
                    if (xi == cw - 1)
                        push_byte(NEWLINE_CHAR);
                    t = text_q.pop_back();
                    t.last = 1'b1;
                    text_q.push_back(t);
                end
            end
        endcase
    endtask

    task automatic send_item(func_t f, logic [9:0] xv, logic [9:0] yv);
        int gap;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 16);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'h0, yv, xv};
        do @(posedge clk); while (!s_tready);
        predict_text(f, xv, yv);
    endtask

    task automatic drain_block();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (text_q.size() != 0) @(posedge clk);
        repeat (clear_pending ? CLEAR_SETTLE : ITEM_SETTLE) @(posedge clk);
        clear_pending = 1'b0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [8:0] val);
        drain_block();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == CFG_WIDTH_PX)
            width_cfg = val;
        else if (idx == CFG_HEIGHT_PX)
            height_cfg = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] pick_coord(int lim, int window);
        int r;
        r = $urandom_range(0, 9);
        if (lim <= 0 || r == 0)
            return 10'($urandom);
        if (r == 1)
            return 10'(lim - 1);
        if (r == 2)
            return 10'(lim);
        if (r < 7 && window < lim)
            return 10'($urandom_range(0, window - 1));
        return 10'($urandom_range(0, lim - 1));
    endfunction

    task automatic send_random(int count);
        int w;
        int h;
        int r;
        func_t f;
        for (int n = 0; n < count; n++)
        begin
            w = eff_size(width_cfg, MAX_WIDTH_PX_DEF);
            h = eff_size(height_cfg, MAX_HEIGHT_PX_DEF);
            r = $urandom_range(0, 99);
            if (r < 40)
                f = FUNC_SET;
            else if (r < 55)
                f = FUNC_UNSET;
            else if (r == 55 && clears_left > 0)
                f = FUNC_CLEAR;
            else
                f = FUNC_RENDER;
            if (f == FUNC_CLEAR)
                clears_left--;
            if (f == FUNC_RENDER)
                send_item(f, pick_coord((w + 1) / 2, 6), pick_coord((h + 3) / 4, 4));
            else
                send_item(f, pick_coord(w, 12), pick_coord(h, 16));
        end
    endtask

    task automatic test_directed();
        send_item(FUNC_SET, 10'd0, 10'd0);
        send_item(FUNC_RENDER, 10'd0, 10'd0);
        send_item(FUNC_SET, 10'd1, 10'd3);
        send_item(FUNC_RENDER, 10'd0, 10'd0);
        send_item(FUNC_UNSET, 10'd0, 10'd0);
        send_item(FUNC_RENDER, 10'd0, 10'd0);
        send_item(FUNC_SET, 10'd255, 10'd255);
        send_item(FUNC_RENDER, 10'd127, 10'd63);
        send_item(FUNC_RENDER, 10'd126, 10'd63);
        send_item(FUNC_SET, 10'(-1), 10'd0);
        send_item(FUNC_SET, 10'd256, 10'd0);
        send_item(FUNC_SET, 10'd0, 10'(-512));
        send_item(FUNC_UNSET, 10'd511, 10'd511);
        send_item(FUNC_RENDER, 10'(-1), 10'd0);
        send_item(FUNC_RENDER, 10'd128, 10'd0);
        send_item(FUNC_RENDER, 10'd0, 10'd64);
        send_item(FUNC_RENDER, 10'(-512), 10'(-512));
        send_item(FUNC_RENDER, 10'd511, 10'd511);
        send_item(FUNC_CLEAR, 10'd0, 10'd0);
        send_item(FUNC_RENDER, 10'd0, 10'd0);
        send_item(FUNC_RENDER, 10'd127, 10'd63);
    endtask

    task automatic test_sizes();
        write_reg(CFG_WIDTH_PX, 9'd1);
        write_reg(CFG_HEIGHT_PX, 9'd1);
        send_random(10);
        write_reg(CFG_WIDTH_PX, 9'd2);
        write_reg(CFG_HEIGHT_PX, 9'd4);
        send_random(12);
        write_reg(CFG_WIDTH_PX, 9'd0);
        write_reg(CFG_HEIGHT_PX, 9'd8);
        send_random(8);
        write_reg(CFG_WIDTH_PX, 9'd8);
        write_reg(CFG_HEIGHT_PX, 9'd0);
        send_random(8);
        write_reg(CFG_WIDTH_PX, 9'd7);
        write_reg(CFG_HEIGHT_PX, 9'd5);
        send_random(16);
        write_reg(CFG_WIDTH_PX, 9'd511);
        write_reg(CFG_HEIGHT_PX, 9'd300);
        send_random(14);
        write_reg(CFG_UNUSED_LO, 9'h1FF);
        write_reg(CFG_UNUSED_HI, 9'h000);
        send_random(10);
        write_reg(CFG_WIDTH_PX, 9'($urandom_range(1, 40)));
        write_reg(CFG_HEIGHT_PX, 9'($urandom_range(1, 40)));
        send_random(16);
        write_reg(CFG_WIDTH_PX, 9'd257);
        write_reg(CFG_HEIGHT_PX, 9'd256);
    endtask

    task automatic test_backpressure();
        for (int n = 0; n < 12; n++)
            send_item(FUNC_SET, 10'($urandom_range(0, 7)), 10'($urandom_range(0, 3)));
        hold_left = 400;
        for (int n = 0; n < 30; n++)
            send_item(FUNC_RENDER, 10'($urandom_range(0, 3)), 10'd0);
    endtask

    task automatic test_steady();
        idle_on = 1'b0;
        send_random(30);
    endtask

    initial
    begin : sink_ctl
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk)
    begin : check_beats
        text_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (text_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat: expected none, actual byte %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = text_q.pop_front();
                if (m_tdata !== want.text_byte)
                begin
                    errors++;
                    $display("%0t: text_byte mismatch: expected %h, actual %h",
                             $time, want.text_byte, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    errors++;
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("braille_cell_framebuffer_core test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        errors    = 0;
        cycles    = 0;
        hold_left = 0;
        idle_on   = 1'b1;
        clears_left = 2;
        clear_pending = 1'b1;
        width_cfg  = WIDTH_PX_RST;
        height_cfg = HEIGHT_PX_RST;
        foreach (cell_masks[i])
            cell_masks[i] = 8'h00;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_sizes();
        send_random(110);
        test_backpressure();
        test_steady();

        drain_block();
        if (errors == 0)
            $display("braille_cell_framebuffer_core test passed");
        else
            $display("braille_cell_framebuffer_core test failed");
        $finish;
    end

endmodule
